FILE: rtl/core/vurp_pkg.sv
// Shared types and constants of the video unit register port.
package vurp_pkg;

  localparam int SpriteMemDepth = 256;
  localparam int DotsPerLine = 341;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_WRITE = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    IDX_CONTROL  = 3'd0,
    IDX_MASK     = 3'd1,
    IDX_STATUS   = 3'd2,
    IDX_SPR_ADDR = 3'd3,
    IDX_SPR_DATA = 3'd4,
    IDX_SCROLL   = 3'd5,
    IDX_ADDR     = 3'd6,
    IDX_DATA     = 3'd7
  } reg_index_t;

  localparam logic [15:0] PaletteBase = 16'h3F00;
  localparam logic [8:0]  LineFrameEnd = 9'd240;
  localparam logic [8:0]  LineVblankOn = 9'd241;
  localparam logic [8:0]  LineLast = 9'd261;
  localparam logic [15:0] StepWide = 16'd32;
  localparam logic [15:0] StepNarrow = 16'd1;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  register_index;
    logic [7:0]  write_data;
    logic [7:0]  tick_dots;
    logic [7:0]  vram_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [15:0] vram_addr;
    logic        vram_write_enable;
    logic [15:0] vram_write_addr;
    logic [7:0]  vram_write_data;
    logic        frame_done;
    logic        vblank_flag;
    logic [8:0]  line_number;
    logic [31:0] frame_total;
  } out_item_t;

endpackage

FILE: rtl/core/vurp_if.sv
// Valid/ready channel interfaces for input and result transactions.
interface vurp_in_if;
  logic                 valid;
  logic                 ready;
  vurp_pkg::in_item_t   data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface vurp_out_if;
  logic                 valid;
  logic                 ready;
  vurp_pkg::out_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/vurp_queue.sv
// Two-entry queue between the front end and the execution back end.
module vurp_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  vurp_pkg::in_item_t push_data,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output vurp_pkg::in_item_t pop_data
);
  import vurp_pkg::*;

  in_item_t   mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign full      = count_r == 2'd2;
  assign not_empty = count_r != 2'd0;
  assign pop_data  = mem_r[rd_ptr_r];
endmodule

FILE: rtl/core/vurp_exec.sv
// Back end: register file, sprite memory, address logic and line timing.
module vurp_exec #(
  parameter int DOTS_PER_LINE = vurp_pkg::DotsPerLine
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_valid,
  input  vurp_pkg::in_item_t  item,
  output logic                item_take,
  output logic                res_valid,
  output vurp_pkg::out_item_t res,
  input  logic                res_ready
);
  import vurp_pkg::*;

  localparam logic [9:0] DotsLine = 10'(DOTS_PER_LINE);

  logic [7:0]  control_r, control_nxt, mask_r, mask_nxt, status_r, status_nxt;
  logic [7:0]  sprite_addr_r, sprite_addr_nxt;
  logic [7:0]  scroll_last_r, scroll_last_nxt, scroll_h_r, scroll_h_nxt;
  logic [7:0]  scroll_v_r, scroll_v_nxt;
  logic        scroll_tog_r, scroll_tog_nxt, addr_tog_r, addr_tog_nxt;
  logic [7:0]  addr_high_r, addr_high_nxt, read_ahead_r, read_ahead_nxt;
  logic [15:0] vaddr_r, vaddr_nxt;
  logic [8:0]  dot_r, dot_nxt, line_r, line_nxt;
  logic [31:0] frame_r, frame_nxt;
  logic [7:0]  sprite_mem_r [SpriteMemDepth];
  logic [SpriteMemDepth-1:0] sprite_vld_r;
  logic [7:0]  spr_rd_r;
  logic        spr_rd_vld_r;
  logic [7:0]  spr_rd_addr;
  logic        oam_we;
  logic        out_valid_r;
  out_item_t   out_r, out_nxt;
  logic        fire;
  logic [9:0]  dot_sum, dot_rem;
  logic [15:0] step;
  logic [7:0]  oam_rd;

  assign item_take = item_valid && (!out_valid_r || res_ready);
  assign fire      = item_take;
  assign step      = control_r[2] ? StepWide : StepNarrow;
  // The sprite read register always holds the entry at the current sprite address.
  assign spr_rd_addr = fire ? sprite_addr_nxt : sprite_addr_r;
  assign oam_rd    = spr_rd_vld_r ? spr_rd_r : 8'd0;
  assign dot_sum   = {1'b0, dot_r} + {2'b00, item.tick_dots};
  assign dot_rem   = dot_sum - DotsLine;

  always_comb begin
    control_nxt = control_r; mask_nxt = mask_r; status_nxt = status_r;
    sprite_addr_nxt = sprite_addr_r; scroll_last_nxt = scroll_last_r;
    scroll_h_nxt = scroll_h_r; scroll_v_nxt = scroll_v_r;
    scroll_tog_nxt = scroll_tog_r; addr_tog_nxt = addr_tog_r;
    addr_high_nxt = addr_high_r; read_ahead_nxt = read_ahead_r;
    vaddr_nxt = vaddr_r; dot_nxt = dot_r; line_nxt = line_r; frame_nxt = frame_r;
    oam_we = 1'b0;
    out_nxt = '0;
    unique case (action_t'(item.action))
      ACT_TICK: begin
        if (dot_sum >= DotsLine) begin
          if (line_r == LineFrameEnd) begin
            frame_nxt = frame_r + 32'd1;
            out_nxt.frame_done = 1'b1;
          end
          if (line_r == LineVblankOn) status_nxt[7] = 1'b1;
          if (line_r == LineLast) begin
            status_nxt[7:6] = 2'b00;
            line_nxt = '0;
          end else begin
            line_nxt = line_r + 9'd1;
          end
          dot_nxt = (dot_rem > 10'd511) ? 9'd511 : dot_rem[8:0];
        end else begin
          dot_nxt = (dot_sum > 10'd511) ? 9'd511 : dot_sum[8:0];
        end
      end
      ACT_READ: begin
        unique case (reg_index_t'(item.register_index))
          IDX_CONTROL:  out_nxt.read_data = control_r;
          IDX_MASK:     out_nxt.read_data = mask_r;
          IDX_STATUS: begin
            out_nxt.read_data = status_r;
            status_nxt[7] = 1'b0;
            addr_tog_nxt = 1'b0;
            scroll_tog_nxt = 1'b0;
          end
          IDX_SPR_ADDR: out_nxt.read_data = sprite_addr_r;
          IDX_SPR_DATA: out_nxt.read_data = oam_rd;
          IDX_SCROLL:   out_nxt.read_data = scroll_last_r;
          IDX_ADDR:     out_nxt.read_data = addr_high_r;
          IDX_DATA: begin
            if (vaddr_r < PaletteBase) begin
              out_nxt.read_data = read_ahead_r;
              read_ahead_nxt = item.vram_data;
            end else begin
              out_nxt.read_data = item.vram_data;
            end
            vaddr_nxt = vaddr_r + step;
          end
          default: ;
        endcase
      end
      ACT_WRITE: begin
        unique case (reg_index_t'(item.register_index))
          IDX_CONTROL:  control_nxt = item.write_data;
          IDX_MASK:     mask_nxt = item.write_data;
          IDX_STATUS: begin
            status_nxt = {1'b0, item.write_data[6:0]};
            addr_tog_nxt = 1'b0;
            scroll_tog_nxt = 1'b0;
          end
          IDX_SPR_ADDR: sprite_addr_nxt = item.write_data;
          IDX_SPR_DATA: oam_we = 1'b1;
          IDX_SCROLL: begin
            if (scroll_tog_r) scroll_v_nxt = item.write_data;
            else scroll_h_nxt = item.write_data;
            scroll_tog_nxt = !scroll_tog_r;
            scroll_last_nxt = item.write_data;
          end
          IDX_ADDR: begin
            if (addr_tog_r) vaddr_nxt = {addr_high_r, item.write_data};
            else addr_high_nxt = item.write_data;
            addr_tog_nxt = !addr_tog_r;
          end
          IDX_DATA: begin
            out_nxt.vram_write_enable = 1'b1;
            out_nxt.vram_write_addr = vaddr_r;
            out_nxt.vram_write_data = item.write_data;
            vaddr_nxt = vaddr_r + step;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    out_nxt.vram_addr   = vaddr_nxt;
    out_nxt.vblank_flag = status_nxt[7];
    out_nxt.line_number = line_nxt;
    out_nxt.frame_total = frame_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      control_r <= '0; mask_r <= '0; status_r <= '0; sprite_addr_r <= '0;
      scroll_last_r <= '0; scroll_h_r <= '0; scroll_v_r <= '0;
      scroll_tog_r <= 1'b0; addr_tog_r <= 1'b0; addr_high_r <= '0;
      read_ahead_r <= '0; vaddr_r <= '0; dot_r <= '0; line_r <= '0;
      frame_r <= '0; sprite_vld_r <= '0; out_valid_r <= 1'b0;
      spr_rd_vld_r <= 1'b0;
    end else begin
      if (fire) begin
        control_r <= control_nxt; mask_r <= mask_nxt; status_r <= status_nxt;
        sprite_addr_r <= sprite_addr_nxt; scroll_last_r <= scroll_last_nxt;
        scroll_h_r <= scroll_h_nxt; scroll_v_r <= scroll_v_nxt;
        scroll_tog_r <= scroll_tog_nxt; addr_tog_r <= addr_tog_nxt;
        addr_high_r <= addr_high_nxt; read_ahead_r <= read_ahead_nxt;
        vaddr_r <= vaddr_nxt; dot_r <= dot_nxt; line_r <= line_nxt;
        frame_r <= frame_nxt;
        if (oam_we) sprite_vld_r[sprite_addr_r] <= 1'b1;
        out_valid_r <= 1'b1;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
      if (fire && oam_we) spr_rd_vld_r <= 1'b1;
      else spr_rd_vld_r <= sprite_vld_r[spr_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (fire) out_r <= out_nxt;
    if (fire && oam_we) begin
      sprite_mem_r[sprite_addr_r] <= item.write_data;
      spr_rd_r <= item.write_data;
    end else begin
      spr_rd_r <= sprite_mem_r[spr_rd_addr];
    end
  end

  assign res_valid = out_valid_r;
  assign res       = out_r;
endmodule

FILE: rtl/core/video_unit_register_port.sv
// Top level of the video unit register port: front queue and back end.
//   channel | direction | handshake
//   in      | sink      | in.valid / in.ready, payload in.data
//   out     | source    | out.valid / out.ready, payload out.data
// One transaction per cycle is sustained while out.ready stays high. An accepted
// input is queued; its result is valid in the cycle after the back end takes it.
// The two-entry queue lets the input side accept until the queue is full while
// the output register waits on a stalled consumer.
// Synchronous active-low reset clears the state registers, not the result data,
// and the sprite memory valid bits at once; no clearing pass is needed.
module video_unit_register_port #(
  parameter int DOTS_PER_LINE = vurp_pkg::DotsPerLine
) (
  input logic       clk,
  input logic       rst_n,
  vurp_in_if.sink   in,
  vurp_out_if.source out
);
  import vurp_pkg::*;

  logic     q_full, q_ne, q_pop;
  in_item_t q_data;
  logic     res_valid;
  out_item_t res;

  assign in.ready = !q_full;

  vurp_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(in.valid && !q_full), .push_data(in.data), .full(q_full),
    .pop(q_pop), .not_empty(q_ne), .pop_data(q_data)
  );

  vurp_exec #(.DOTS_PER_LINE(DOTS_PER_LINE)) u_exec (
    .clk(clk), .rst_n(rst_n),
    .item_valid(q_ne), .item(q_data), .item_take(q_pop),
    .res_valid(res_valid), .res(res), .res_ready(out.ready)
  );

  assign out.valid = res_valid;
  assign out.data  = res;
endmodule

FILE: tb/tb_video_unit_register_port.sv
// Self-checking testbench of the video unit register port: directed rows, then random traffic.
module tb_video_unit_register_port;
  import vurp_pkg::*;

  logic clk;
  logic rst_n;
  vurp_in_if  in_ch ();
  vurp_out_if out_ch ();

  video_unit_register_port dut (.clk(clk), .rst_n(rst_n), .in(in_ch), .out(out_ch));

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Shadow state of the register port.
  logic [7:0]  ctrl_q, mask_q, stat_q, oam_addr_q, scroll_last_q, addr_hi_q, buf_q;
  logic [7:0]  oam_q [256];
  logic        scroll_tog_q, addr_tog_q;
  logic [15:0] vaddr_q;
  logic [9:0]  dots_q;
  logic [8:0]  line_q;
  logic [31:0] frames_q;

  out_item_t expected_results [$];
  int        error_count = 0;
  int        result_count = 0;
  int        frames_seen = 0;
  bit        stall_enable = 1'b1;

  // One directed row: the transaction and, where it is obvious, its result.
  typedef struct {
    in_item_t  item;
    bit        has_known;
    out_item_t known;
  } dir_row_t;

  task automatic reset_shadow();
    ctrl_q = '0; mask_q = '0; stat_q = '0; oam_addr_q = '0; scroll_last_q = '0;
    addr_hi_q = '0; buf_q = '0; scroll_tog_q = 1'b0; addr_tog_q = 1'b0;
    vaddr_q = '0; dots_q = '0; line_q = '0; frames_q = '0;
    foreach (oam_q[i]) oam_q[i] = '0;
  endtask

  function automatic out_item_t predict_port(in_item_t it);
    out_item_t r;
    logic [10:0] sum;
    r = '0;
    case (it.action)
      ACT_TICK: begin
        sum = dots_q + it.tick_dots;
        if (sum >= DotsPerLine) begin
          if (line_q == LineFrameEnd) begin
            frames_q++;
            r.frame_done = 1'b1;
          end
          if (line_q == LineVblankOn) stat_q[7] = 1'b1;
          if (line_q == LineLast) begin
            stat_q[7:6] = 2'b00;
            line_q = '0;
          end else begin
            line_q = line_q + 9'd1;
          end
          sum = sum - 11'(DotsPerLine);
        end
        dots_q = (sum > 511) ? 10'd511 : sum[9:0];
      end
      ACT_READ: begin
        case (reg_index_t'(it.register_index))
          IDX_CONTROL:  r.read_data = ctrl_q;
          IDX_MASK:     r.read_data = mask_q;
          IDX_STATUS: begin
            r.read_data = stat_q;
            stat_q[7] = 1'b0;
            addr_tog_q = 1'b0;
            scroll_tog_q = 1'b0;
          end
          IDX_SPR_ADDR: r.read_data = oam_addr_q;
          IDX_SPR_DATA: r.read_data = oam_q[oam_addr_q];
          IDX_SCROLL:   r.read_data = scroll_last_q;
          IDX_ADDR:     r.read_data = addr_hi_q;
          IDX_DATA: begin
            if (vaddr_q < PaletteBase) begin
              r.read_data = buf_q;
              buf_q = it.vram_data;
            end else begin
              r.read_data = it.vram_data;
            end
            vaddr_q = vaddr_q + (ctrl_q[2] ? StepWide : StepNarrow);
          end
        endcase
      end
      ACT_WRITE: begin
        case (reg_index_t'(it.register_index))
          IDX_CONTROL:  ctrl_q = it.write_data;
          IDX_MASK:     mask_q = it.write_data;
          IDX_STATUS: begin
            stat_q = it.write_data & 8'h7F;
            addr_tog_q = 1'b0;
            scroll_tog_q = 1'b0;
          end
          IDX_SPR_ADDR: oam_addr_q = it.write_data;
          IDX_SPR_DATA: oam_q[oam_addr_q] = it.write_data;
          IDX_SCROLL: begin
            scroll_tog_q = ~scroll_tog_q;
            scroll_last_q = it.write_data;
          end
          IDX_ADDR: begin
            if (addr_tog_q) vaddr_q = {addr_hi_q, it.write_data};
            else addr_hi_q = it.write_data;
            addr_tog_q = ~addr_tog_q;
          end
          IDX_DATA: begin
            r.vram_write_enable = 1'b1;
            r.vram_write_addr = vaddr_q;
            r.vram_write_data = it.write_data;
            vaddr_q = vaddr_q + (ctrl_q[2] ? StepWide : StepNarrow);
          end
        endcase
      end
      default: ;
    endcase
    r.vram_addr = vaddr_q;
    r.vblank_flag = stat_q[7];
    r.line_number = line_q;
    r.frame_total = frames_q;
    return r;
  endfunction

  function automatic in_item_t make_item(action_t a, reg_index_t idx, logic [7:0] wd,
                                         logic [7:0] dots, logic [7:0] vram);
    in_item_t it;
    it.action = a;
    it.register_index = idx;
    it.write_data = wd;
    it.tick_dots = dots;
    it.vram_data = vram;
    return it;
  endfunction

  // Random idle gap on the input now and then, with long quiet stretches.
  task automatic idle_gap();
    int n;
    n = 0;
    if (stall_enable && $urandom_range(0, 5) == 0) n = $urandom_range(1, 14);
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // Drives one transaction and holds it until it is accepted.
  task automatic send_item(in_item_t it, bit has_known, out_item_t known);
    out_item_t pred;
    idle_gap();
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    pred = predict_port(it);
    if (has_known && pred !== known) begin
      $error("directed row disagrees with predictor: exp %h got %h", known, pred);
      error_count++;
    end
    expected_results.push_back(pred);
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic send_plain(in_item_t it);
    send_item(it, 1'b0, '0);
  endtask

  // Checks each result transaction against the oldest expectation.
  always @(posedge clk) begin
    out_item_t exp_r, got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      result_count++;
      if (expected_results.size() == 0) begin
        $error("result with no expectation: %h", got);
        error_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (got.frame_done) frames_seen++;
        if (got.read_data !== exp_r.read_data) begin
          $error("read_data exp %h got %h", exp_r.read_data, got.read_data); error_count++;
        end
        if (got.vram_addr !== exp_r.vram_addr) begin
          $error("vram_addr exp %h got %h", exp_r.vram_addr, got.vram_addr); error_count++;
        end
        if (got.vram_write_enable !== exp_r.vram_write_enable) begin
          $error("vram_write_enable exp %b got %b", exp_r.vram_write_enable,
                 got.vram_write_enable);
          error_count++;
        end
        if (got.vram_write_addr !== exp_r.vram_write_addr) begin
          $error("vram_write_addr exp %h got %h", exp_r.vram_write_addr, got.vram_write_addr);
          error_count++;
        end
        if (got.vram_write_data !== exp_r.vram_write_data) begin
          $error("vram_write_data exp %h got %h", exp_r.vram_write_data, got.vram_write_data);
          error_count++;
        end
        if (got.frame_done !== exp_r.frame_done) begin
          $error("frame_done exp %b got %b", exp_r.frame_done, got.frame_done); error_count++;
        end
        if (got.vblank_flag !== exp_r.vblank_flag) begin
          $error("vblank_flag exp %b got %b", exp_r.vblank_flag, got.vblank_flag);
          error_count++;
        end
        if (got.line_number !== exp_r.line_number) begin
          $error("line_number exp %0d got %0d", exp_r.line_number, got.line_number);
          error_count++;
        end
        if (got.frame_total !== exp_r.frame_total) begin
          $error("frame_total exp %0d got %0d", exp_r.frame_total, got.frame_total);
          error_count++;
        end
      end
    end
  end

  // The consumer stalls in random bursts while stalling is enabled.
  initial begin
    int n;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_enable && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 14);
        out_ch.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  initial begin
    #400000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    dir_row_t rows [$];
    dir_row_t row;
    in_item_t it;
    out_item_t k;
    int pick;
    int wait_cycles;

    in_ch.valid = 1'b0;
    in_ch.data = '0;
    rst_n = 1'b0;
    reset_shadow();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed rows; results given only where they are plain.
    k = '0;
    row.item = make_item(ACT_READ, IDX_STATUS, 8'h00, 8'h00, 8'h00);
    row.has_known = 1'b1; row.known = k; rows.push_back(row);
    row.item = make_item(ACT_WRITE, IDX_DATA, 8'hFF, 8'hFF, 8'hFF);
    k = '0; k.vram_write_enable = 1'b1; k.vram_write_data = 8'hFF; k.vram_addr = 16'd1;
    row.known = k; rows.push_back(row);
    row.has_known = 1'b0;
    row.item = make_item(ACT_WRITE, IDX_CONTROL, 8'hFF, 8'h00, 8'h00); rows.push_back(row);
    row.item = make_item(ACT_WRITE, IDX_MASK, 8'hA5, 8'h00, 8'h00); rows.push_back(row);
    row.item = make_item(ACT_WRITE, IDX_SPR_ADDR, 8'hFF, 8'h00, 8'h00); rows.push_back(row);
    row.item = make_item(ACT_WRITE, IDX_SPR_DATA, 8'h5A, 8'h00, 8'h00); rows.push_back(row);
    row.item = make_item(ACT_READ, IDX_SPR_DATA, 8'h00, 8'h00, 8'h00); rows.push_back(row);
    row.item = make_item(ACT_WRITE, IDX_SCROLL, 8'h12, 8'h00, 8'h00); rows.push_back(row);
    row.item = make_item(ACT_WRITE, IDX_SCROLL, 8'h34, 8'h00, 8'h00); rows.push_back(row);
    row.item = make_item(ACT_READ, IDX_SCROLL, 8'h00, 8'h00, 8'h00); rows.push_back(row);
    row.item = make_item(ACT_WRITE, IDX_ADDR, 8'hFF, 8'h00, 8'h00); rows.push_back(row);
    row.item = make_item(ACT_WRITE, IDX_ADDR, 8'hF0, 8'h00, 8'h00); rows.push_back(row);
    // Wide step wraps the address; then a palette read returns memory directly.
    row.item = make_item(ACT_WRITE, IDX_DATA, 8'h01, 8'h00, 8'h00); rows.push_back(row);
    row.item = make_item(ACT_WRITE, IDX_ADDR, 8'h3F, 8'h00, 8'h00); rows.push_back(row);
    row.item = make_item(ACT_WRITE, IDX_ADDR, 8'h00, 8'h00, 8'h00); rows.push_back(row);
    row.item = make_item(ACT_READ, IDX_DATA, 8'h00, 8'h00, 8'hC3); rows.push_back(row);
    row.item = make_item(ACT_WRITE, IDX_ADDR, 8'h3E, 8'h00, 8'h00); rows.push_back(row);
    row.item = make_item(ACT_WRITE, IDX_ADDR, 8'hFF, 8'h00, 8'h00); rows.push_back(row);
    row.item = make_item(ACT_READ, IDX_DATA, 8'h00, 8'h00, 8'h77); rows.push_back(row);
    row.item = make_item(ACT_READ, IDX_ADDR, 8'h00, 8'h00, 8'h00); rows.push_back(row);
    row.item = make_item(ACT_WRITE, IDX_STATUS, 8'hFF, 8'h00, 8'h00); rows.push_back(row);
    row.item = make_item(ACT_READ, IDX_STATUS, 8'h00, 8'h00, 8'h00); rows.push_back(row);
    row.item = make_item(ACT_NONE, IDX_DATA, 8'hFF, 8'hFF, 8'hFF); rows.push_back(row);
    row.item = make_item(ACT_TICK, IDX_CONTROL, 8'h00, 8'hFF, 8'h00); rows.push_back(row);
    row.item = make_item(ACT_TICK, IDX_CONTROL, 8'h00, 8'hFF, 8'h00); rows.push_back(row);
    foreach (rows[i]) send_item(rows[i].item, rows[i].has_known, rows[i].known);

    // Random traffic, mostly ticks so at least one whole frame and its vblank phase pass.
    for (int n = 0; n < 1330; n++) begin
      if (n == 1100) stall_enable = 1'b0;
      if (n == 600) begin
        // Hold off until the port has drained.
        in_ch.valid <= 1'b0;
        wait (expected_results.size() == 0);
        @(negedge clk);
      end
      pick = $urandom_range(0, 99);
      it.write_data = 8'($urandom_range(0, 255));
      it.vram_data = 8'($urandom_range(0, 255));
      it.tick_dots = 8'($urandom_range(0, 255));
      it.register_index = 3'($urandom_range(0, 7));
      if (pick < 70) it.action = ACT_TICK;
      else if (pick < 84) it.action = ACT_READ;
      else if (pick < 98) it.action = ACT_WRITE;
      else it.action = ACT_NONE;
      send_plain(it);
    end
    in_ch.valid <= 1'b0;

    wait_cycles = 0;
    while (expected_results.size() != 0 && wait_cycles < 5000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (10) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      error_count++;
    end
    $display("Covered %0d transactions over %0d completed frames, with every register",
             result_count, frames_seen);
    $display("read and written under random idling on both channels.");
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/vurp_pkg.sv
rtl/core/vurp_if.sv
rtl/core/vurp_queue.sv
rtl/core/vurp_exec.sv
rtl/core/video_unit_register_port.sv
tb/tb_video_unit_register_port.sv
